[design/ecd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_pkg: shared types and constants for the epoch to calendar date block
// Widths of the running remainder, calendar constants and month lengths.
// ----------------------------------------------------------------------------
package ecd_pkg;

   // remainder of seconds; clamped local time always fits in 32 bits
   localparam int RestWidth = 32;

   typedef logic [RestWidth-1:0] rest_type;

   localparam int SecsPerMin   = 60;
   localparam int SecsPerHour  = 3600;
   localparam int SecsPerDay   = 86400;
   localparam int EpochYear    = 1970;
   localparam int YearSecs     = 365 * SecsPerDay;
   localparam int LeapYearSecs = 366 * SecsPerDay;

   localparam int MonthCount = 12;

   // month index 0 is January
   typedef logic [3:0] month_idx_type;

   // length of a month in seconds, February follows the leap flag
   function automatic rest_type month_secs(input month_idx_type idx, input logic leap);
      rest_type secs;
      begin
         case (idx)
            4'd1:    secs = leap ? rest_type'(29 * SecsPerDay) : rest_type'(28 * SecsPerDay);
            4'd3,
            4'd5,
            4'd8,
            4'd10:   secs = rest_type'(30 * SecsPerDay);
            default: secs = rest_type'(31 * SecsPerDay);
         endcase
         return secs;
      end
   endfunction

endpackage

[design/epoch_to_calendar_date.sv]
`timescale 1ns / 1ps
// From the accepting edge the sequencer strips one whole year per step (up to 68),
// then one whole month per step (up to 11), then forms the day, hour and minute
// quotients bit by bit in ST_DAY, ST_HOUR and ST_MINUTE, and captures the item in ST_DONE.
// One item at a time: the next is accepted in the cycle that shows the result.
// Reset (synchronous, active high) idles the sequencer and sets the offset to +9 h.
// Results show for one cycle on rsp_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
// epoch_to_calendar_date: seconds since the epoch to local civil date and time
// Adds the zone offset, clamps at zero, strips years and months by repeated
// subtraction, then splits the rest into day, hour, minute and second.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date
   import ecd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [16:0] csr_zone_offset_seconds,
   // request
   input  logic        start,
   output logic        busy,
   input  logic [30:0] req_epoch_seconds,
   // response
   output logic        rsp_valid,
   output logic [10:0] rsp_year,
   output logic [3:0]  rsp_month_number,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour_of_day,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [5:0]  rsp_second_of_minute
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_YEAR,
      ST_MONTH,
      ST_DAY,
      ST_HOUR,
      ST_MINUTE,
      ST_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [16:0]   zone_ff, zone_in;
   rest_type      rest_ff, rest_in;
   logic [10:0]   year_ff, year_in;
   logic [6:0]    cent_ff, cent_in;     // year mod 100
   logic [8:0]    quad_ff, quad_in;     // year mod 400
   month_idx_type month_ff, month_in;
   logic [2:0]    step_ff, step_in;     // quotient bit position
   logic [4:0]    dayq_ff, dayq_in;
   logic [4:0]    hourq_ff, hourq_in;
   logic [5:0]    minq_ff, minq_in;

   logic          valid_ff, valid_in;
   logic [10:0]   oyear_ff, oyear_in;
   logic [3:0]    omonth_ff, omonth_in;
   logic [4:0]    oday_ff, oday_in;
   logic [4:0]    ohour_ff, ohour_in;
   logic [5:0]    omin_ff, omin_in;
   logic [5:0]    osec_ff, osec_in;

   logic          leap;
   logic          covers;
   rest_type      subtrahend;
   rest_type      difference;
   logic [32:0]   local_sum;

   // Gregorian leap rule on the tracked residues
   assign leap = ((year_ff[1:0] == 2'd0) && (cent_ff != 7'd0)) || (quad_ff == 9'd0);

   // local time, clamped at zero
   assign local_sum = {2'b00, req_epoch_seconds} + {{16{zone_ff[16]}}, zone_ff};

   // subtrahend for the current step
   always_comb begin
      case (state_ff)
         ST_YEAR:   subtrahend = leap ? rest_type'(LeapYearSecs) : rest_type'(YearSecs);
         ST_MONTH:  subtrahend = month_secs(month_ff, leap);
         ST_DAY:    subtrahend = rest_type'(SecsPerDay) << step_ff;
         ST_HOUR:   subtrahend = rest_type'(SecsPerHour) << step_ff;
         ST_MINUTE: subtrahend = rest_type'(SecsPerMin) << step_ff;
         default:   subtrahend = '0;
      endcase
   end

   ecd_cmp_sub u_cmp_sub (
      .minuend    (rest_ff),
      .subtrahend (subtrahend),
      .covers     (covers),
      .difference (difference)
   );

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      zone_in   = zone_ff;
      rest_in   = rest_ff;
      year_in   = year_ff;
      cent_in   = cent_ff;
      quad_in   = quad_ff;
      month_in  = month_ff;
      step_in   = step_ff;
      dayq_in   = dayq_ff;
      hourq_in  = hourq_ff;
      minq_in   = minq_ff;
      valid_in  = 1'b0;
      oyear_in  = oyear_ff;
      omonth_in = omonth_ff;
      oday_in   = oday_ff;
      ohour_in  = ohour_ff;
      omin_in   = omin_ff;
      osec_in   = osec_ff;

      if (csr_write_enable) begin
         zone_in = csr_zone_offset_seconds;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rest_in  = local_sum[32] ? '0 : local_sum[RestWidth-1:0];
               year_in  = 11'(EpochYear);
               cent_in  = 7'(EpochYear % 100);
               quad_in  = 9'(EpochYear % 400);
               month_in = '0;
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (covers) begin
               rest_in = difference;
               year_in = year_ff + 11'd1;
               cent_in = (cent_ff == 7'd99) ? 7'd0 : cent_ff + 7'd1;
               quad_in = (quad_ff == 9'd399) ? 9'd0 : quad_ff + 9'd1;
            end else begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (covers && (month_ff != month_idx_type'(MonthCount - 1))) begin
               rest_in  = difference;
               month_in = month_ff + 4'd1;
            end else begin
               step_in  = 3'd4;
               state_in = ST_DAY;
            end
         end
         ST_DAY: begin
            if (covers) begin
               rest_in = difference;
            end
            dayq_in = {dayq_ff[3:0], covers};
            if (step_ff == 3'd0) begin
               step_in  = 3'd4;
               state_in = ST_HOUR;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         ST_HOUR: begin
            if (covers) begin
               rest_in = difference;
            end
            hourq_in = {hourq_ff[3:0], covers};
            if (step_ff == 3'd0) begin
               step_in  = 3'd5;
               state_in = ST_MINUTE;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         ST_MINUTE: begin
            if (covers) begin
               rest_in = difference;
            end
            minq_in = {minq_ff[4:0], covers};
            if (step_ff == 3'd0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         ST_DONE: begin
            // capture the item so the next request can start at once
            valid_in  = 1'b1;
            oyear_in  = year_ff;
            omonth_in = month_ff + 4'd1;
            oday_in   = dayq_ff + 5'd1;
            ohour_in  = hourq_ff;
            omin_in   = minq_ff;
            osec_in   = rest_ff[5:0];
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         zone_ff  <= 17'(32400);
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         zone_ff  <= zone_in;
         valid_ff <= valid_in;
      end
      rest_ff   <= rest_in;
      year_ff   <= year_in;
      cent_ff   <= cent_in;
      quad_ff   <= quad_in;
      month_ff  <= month_in;
      step_ff   <= step_in;
      dayq_ff   <= dayq_in;
      hourq_ff  <= hourq_in;
      minq_ff   <= minq_in;
      oyear_ff  <= oyear_in;
      omonth_ff <= omonth_in;
      oday_ff   <= oday_in;
      ohour_ff  <= ohour_in;
      omin_ff   <= omin_in;
      osec_ff   <= osec_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = valid_ff;
   assign rsp_year             = oyear_ff;
   assign rsp_month_number     = omonth_ff;
   assign rsp_day_of_month     = oday_ff;
   assign rsp_hour_of_day      = ohour_ff;
   assign rsp_minute_of_hour   = omin_ff;
   assign rsp_second_of_minute = osec_ff;

endmodule

[design/ecd_cmp_sub.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_cmp_sub: shared compare and subtract unit
// Tells whether the remainder covers the subtrahend and gives the difference.
// ----------------------------------------------------------------------------
module ecd_cmp_sub
   import ecd_pkg::*;
(
   input  rest_type minuend,
   input  rest_type subtrahend,
   output logic     covers,
   output rest_type difference
);

   logic [RestWidth:0] wide_diff;

   // one wide subtract; the borrow out is the compare
   assign wide_diff  = {1'b0, minuend} - {1'b0, subtrahend};
   assign covers     = ~wide_diff[RestWidth];
   assign difference = wide_diff[RestWidth-1:0];

endmodule
